// ----- src/cges_pkg.sv -----
package cges_pkg;

	localparam int FracBits  = 16;
	localparam int PixelBits = 12;
	localparam int WorkFrac  = 8;

	localparam logic [30:0] GravityReset = 31'd163840000;
	localparam logic [15:0] ThrustReset  = 16'd3277;
	localparam logic [11:0] WidthReset   = 12'd1500;
	localparam logic [11:0] HeightReset  = 12'd800;
	localparam logic [27:0] StartXReset  = 28'd55705600;
	localparam logic [27:0] StartYReset  = 28'd39321600;
	localparam logic [31:0] StartVxReset = 32'd196608;
	localparam logic [31:0] StartVyReset = 32'd0;

	localparam logic [2:0] RegGravity = 3'd0;
	localparam logic [2:0] RegThrust  = 3'd1;
	localparam logic [2:0] RegWidth   = 3'd2;
	localparam logic [2:0] RegHeight  = 3'd3;
	localparam logic [2:0] RegStartX  = 3'd4;
	localparam logic [2:0] RegStartY  = 3'd5;
	localparam logic [2:0] RegStartVx = 3'd6;
	localparam logic [2:0] RegStartVy = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIFF,
		ST_SQ,
		ST_DIV,
		ST_SQRT,
		ST_MULX,
		ST_DIVX,
		ST_MULY,
		ST_DIVY,
		ST_UPDV,
		ST_UPDP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [11:0] attractor_x;
		logic [11:0] attractor_y;
		logic        thrust_up;
		logic        thrust_down;
		logic        thrust_left;
		logic        thrust_right;
		logic        restart;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic               out_of_bounds;
	} out_item_t;

endpackage

// ----- src/cges_if.sv -----
interface cges_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/central_gravity_euler_step.sv -----
// path: restart, halted or out-of-field ticks go from ST_CHECK straight to ST_OUT,
// a tick at zero distance skips the divides and the root (ST_SQ to ST_UPDV), a moving tick runs them all
// (47-step divide, 32-step root and two 66-step divides share one restoring unit)
// throughput: one item at a time; in.ready is low from acceptance until the result is taken
// reset: arst_n clears registers to their defaults, body at the start position, not halted
module central_gravity_euler_step
	import cges_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cges_if.sink        in,
	cges_if.source      out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int Shift = FracBits - WorkFrac;

	logic [30:0] grav_q;
	logic [15:0] thr_q;
	logic [11:0] fw_q, fh_q;
	logic [27:0] sx_q, sy_q;
	logic [31:0] svx_q, svy_q;

	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic halted_q;
	in_item_t it_q;
	state_t state_q, state_d;

	logic signed [33:0] dx_q, dy_q;
	logic [25:0] wx_q, wy_q;
	logic [52:0] r2_q;
	logic [38:0] q_q;
	logic [26:0] r_q;
	logic signed [39:0] ax_q, ay_q;

	// shared serial unit: restoring divide or integer square root
	logic [6:0]  cnt_q;
	logic [65:0] num_q;
	logic [65:0] rem_q;
	logic [65:0] quo_q;
	logic [65:0] den_q;
	logic        sq_mode_q;

	assign pready = 1'b1;
	wire wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[4:2])
			RegGravity: prdata = {1'b0, grav_q};
			RegThrust:  prdata = {16'd0, thr_q};
			RegWidth:   prdata = {20'd0, fw_q};
			RegHeight:  prdata = {20'd0, fh_q};
			RegStartX:  prdata = {4'd0, sx_q};
			RegStartY:  prdata = {4'd0, sy_q};
			RegStartVx: prdata = svx_q;
			RegStartVy: prdata = svy_q;
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GravityReset; thr_q <= ThrustReset;
			fw_q <= WidthReset; fh_q <= HeightReset;
			sx_q <= StartXReset; sy_q <= StartYReset;
			svx_q <= StartVxReset; svy_q <= StartVyReset;
		end else if (wr) begin
			unique case (paddr[4:2])
				RegGravity: grav_q <= pwdata[30:0];
				RegThrust:  thr_q <= pwdata[15:0];
				RegWidth:   fw_q <= pwdata[11:0];
				RegHeight:  fh_q <= pwdata[11:0];
				RegStartX:  sx_q <= pwdata[27:0];
				RegStartY:  sy_q <= pwdata[27:0];
				RegStartVx: svx_q <= pwdata;
				RegStartVy: svy_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign in.ready  = (state_q == ST_IDLE);
	assign out.valid = (state_q == ST_OUT);
	assign out.data  = '{position_x: px_q, position_y: py_q, velocity_x: vx_q,
		velocity_y: vy_q, out_of_bounds: halted_q};

	wire unit_done = (cnt_q == 7'd0);

	// squared distance and the q*w product
	logic [52:0] r2_c;
	logic [65:0] mul_p;
	assign r2_c = 53'(wx_q) * 53'(wx_q) + 53'(wy_q) * 53'(wy_q);
	assign mul_p = 66'(q_q) * 66'((state_q == ST_MULY) ? wy_q : wx_q);

	// one restoring step
	logic [65:0] trial;
	logic [65:0] rem_sh;
	logic [65:0] num_sh;
	always_comb begin
		if (sq_mode_q) begin
			rem_sh = {rem_q[63:0], num_q[65:64]};
			num_sh = {num_q[63:0], 2'b00};
			trial  = {quo_q[63:0], 2'b01};
		end else begin
			rem_sh = {rem_q[64:0], num_q[65]};
			num_sh = {num_q[64:0], 1'b0};
			trial  = den_q;
		end
	end

	// accel helpers
	logic signed [40:0] tx, ty;
	always_comb begin
		tx = 41'(ax_q);
		ty = 41'(ay_q);
		if (it_q.thrust_left)  tx = tx - 41'(thr_q);
		if (it_q.thrust_right) tx = tx + 41'(thr_q);
		if (it_q.thrust_up)    ty = ty - 41'(thr_q);
		if (it_q.thrust_down)  ty = ty + 41'(thr_q);
	end

	function automatic logic signed [31:0] sat(input logic signed [41:0] v);
		if (v > 42'sd2147483647) return 32'h7fffffff;
		if (v < -42'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	logic signed [33:0] fwx, fhy;
	assign fwx = 34'(signed'({1'b0, fw_q})) <<< FracBits;
	assign fhy = 34'(signed'({1'b0, fh_q})) <<< FracBits;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (it_q.restart || halted_q) state_d = ST_OUT;
				else if (px_q < 0 || py_q < 0 || 34'(px_q) > fwx || 34'(py_q) > fhy)
					state_d = ST_OUT;
				else state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_SQ;
			ST_SQ:   state_d = (wx_q == '0 && wy_q == '0) ? ST_UPDV : ST_DIV;
			ST_DIV:  if (unit_done) state_d = ST_SQRT;
			ST_SQRT: if (unit_done) state_d = ST_MULX;
			ST_MULX: state_d = ST_DIVX;
			ST_DIVX: if (unit_done) state_d = ST_MULY;
			ST_MULY: state_d = ST_DIVY;
			ST_DIVY: if (unit_done) state_d = ST_UPDV;
			ST_UPDV: state_d = ST_UPDP;
			ST_UPDP: state_d = ST_OUT;
			ST_OUT:  if (out.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= 32'(StartXReset); py_q <= 32'(StartYReset);
			vx_q <= StartVxReset; vy_q <= StartVyReset;
			halted_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cnt_q != 7'd0) begin
				num_q <= num_sh;
				cnt_q <= cnt_q - 7'd1;
				if (rem_sh >= trial) begin
					rem_q <= rem_sh - trial;
					quo_q <= {quo_q[64:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[64:0], 1'b0};
				end
			end
			unique case (state_q)
				ST_IDLE: if (in.valid) it_q <= in.data;
				ST_CHECK: begin
					if (it_q.restart) begin
						px_q <= 32'(sx_q); py_q <= 32'(sy_q);
						vx_q <= svx_q; vy_q <= svy_q;
						halted_q <= 1'b0;
					end else if (!halted_q &&
						(px_q < 0 || py_q < 0 || 34'(px_q) > fwx || 34'(py_q) > fhy)) begin
						halted_q <= 1'b1;
					end
					dx_q <= (34'(signed'({1'b0, it_q.attractor_x[PixelBits-1:0]})) <<< FracBits)
						- 34'(px_q);
					dy_q <= (34'(signed'({1'b0, it_q.attractor_y[PixelBits-1:0]})) <<< FracBits)
						- 34'(py_q);
				end
				ST_DIFF: begin
					wx_q <= 26'((dx_q < 0 ? -dx_q : dx_q) >> Shift);
					wy_q <= 26'((dy_q < 0 ? -dy_q : dy_q) >> Shift);
					ax_q <= '0; ay_q <= '0;
				end
				ST_SQ: begin
					r2_q <= r2_c;
					// start divide grav<<16 / r2
					num_q <= 66'({grav_q, 16'd0}) << 19;
					rem_q <= '0; quo_q <= '0;
					den_q <= 66'(r2_c);
					sq_mode_q <= 1'b0;
					cnt_q <= 7'd47;
				end
				ST_DIV: if (unit_done) begin
					q_q <= (quo_q > 66'(39'h4000000000)) ? 39'h4000000000 : quo_q[38:0];
					num_q <= 66'(r2_q) << 2;
					rem_q <= '0; quo_q <= '0;
					sq_mode_q <= 1'b1;
					cnt_q <= 7'd32;
				end
				ST_SQRT: if (unit_done) r_q <= quo_q[26:0];
				ST_MULX: begin
					num_q <= mul_p;
					rem_q <= '0; quo_q <= '0;
					den_q <= 66'(r_q);
					sq_mode_q <= 1'b0;
					cnt_q <= 7'd66;
				end
				ST_DIVX: if (unit_done) ax_q <= dx_q < 0 ? -40'(quo_q) : 40'(quo_q);
				ST_MULY: begin
					num_q <= mul_p;
					rem_q <= '0; quo_q <= '0;
					den_q <= 66'(r_q);
					sq_mode_q <= 1'b0;
					cnt_q <= 7'd66;
				end
				ST_DIVY: if (unit_done) ay_q <= dy_q < 0 ? -40'(quo_q) : 40'(quo_q);
				ST_UPDV: begin
					vx_q <= sat(42'(vx_q) + 42'(tx));
					vy_q <= sat(42'(vy_q) + 42'(ty));
				end
				ST_UPDP: begin
					px_q <= sat(42'(px_q) + 42'(vx_q));
					py_q <= sat(42'(py_q) + 42'(vy_q));
				end
				default: ;
			endcase
		end
	end

endmodule
